>>> src/u2u_pkg.sv
`timescale 1ns / 1ps
package u2u_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned UnitW    = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CpW      = 21;
  localparam int unsigned ClassW   = 4;
  localparam int unsigned StateW   = 4;
  localparam int unsigned NumStates = 9;

  localparam logic [StateW-1:0] StAccept = 4'd0;
  localparam logic [StateW-1:0] StReject = 4'd1;

  localparam logic [UnitW-1:0] HiSurrBase = 16'hD7C0;
  localparam logic [UnitW-1:0] LoSurrBase = 16'hDC00;

  // one request from front to back: a single unit or a surrogate pair
  typedef struct packed {
    logic              pair;
    logic [UnitW-1:0]  unit0;
    logic [UnitW-1:0]  unit1;
    logic [CountW-1:0] count0;
  } entry_t;

  function automatic logic [ClassW-1:0] byte_class(input logic [ByteW-1:0] b);
    logic [ClassW-1:0] c;
    if (b < 8'h80) c = 4'd0;
    else if (b < 8'h90) c = 4'd1;
    else if (b < 8'hA0) c = 4'd9;
    else if (b < 8'hC0) c = 4'd7;
    else if (b < 8'hC2) c = 4'd8;
    else if (b < 8'hE0) c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0) c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4) c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else c = 4'd8;
    return c;
  endfunction

  function automatic logic [StateW-1:0] next_state(input logic [StateW-1:0] st,
                                                   input logic [ClassW-1:0] cls);
    logic [StateW-1:0] n;
    n = StReject;
    case (st)
      4'd0: begin
        case (cls)
          4'd0:    n = 4'd0;
          4'd2:    n = 4'd2;
          4'd3:    n = 4'd3;
          4'd4:    n = 4'd5;
          4'd5:    n = 4'd8;
          4'd6:    n = 4'd7;
          4'd10:   n = 4'd4;
          4'd11:   n = 4'd6;
          default: n = StReject;
        endcase
      end
      4'd2: begin
        if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) n = 4'd0;
      end
      4'd3: begin
        if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) n = 4'd2;
      end
      4'd4: begin
        if (cls == 4'd7) n = 4'd2;
      end
      4'd5: begin
        if (cls == 4'd1 || cls == 4'd9) n = 4'd2;
      end
      4'd6: begin
        if (cls == 4'd7 || cls == 4'd9) n = 4'd3;
      end
      4'd7: begin
        if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) n = 4'd3;
      end
      4'd8: begin
        if (cls == 4'd1) n = 4'd3;
      end
      default: n = StReject;
    endcase
    return n;
  endfunction

endpackage

>>> src/u2u_front.sv
`timescale 1ns / 1ps
module u2u_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [u2u_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [u2u_pkg::ByteW-1:0]     in_byte_i,
  input  logic                          in_eos_i,
  output logic                          push_o,
  output u2u_pkg::entry_t               push_entry_o,
  input  logic                          q_full_i
);

  logic [u2u_pkg::CountW-1:0] cap_q;
  logic [u2u_pkg::StateW-1:0] state_q, state_d;
  logic [u2u_pkg::CpW-1:0]    cp_q, cp_d;
  logic [u2u_pkg::CountW-1:0] units_q, units_d;

  logic                       accept;
  logic                       active;
  logic [u2u_pkg::StateW-1:0] st;
  logic [u2u_pkg::ClassW-1:0] cls;
  logic [u2u_pkg::CpW-1:0]    cp_new;
  logic [u2u_pkg::StateW-1:0] nst;
  logic                       is_pair;
  logic [u2u_pkg::CountW-1:0] room;
  logic                       complete;
  logic                       push;
  logic [u2u_pkg::ByteW-1:0]  lead_mask;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign active     = units_q < cap_q;
  assign st         = (state_q >= u2u_pkg::StateW'(u2u_pkg::NumStates)) ?
                      u2u_pkg::StReject : state_q;
  assign cls        = u2u_pkg::byte_class(in_byte_i);
  assign lead_mask  = 8'hFF >> cls;
  assign cp_new     = (st != u2u_pkg::StAccept) ?
                      {cp_q[u2u_pkg::CpW-7:0], in_byte_i[5:0]} :
                      {{(u2u_pkg::CpW-u2u_pkg::ByteW){1'b0}}, lead_mask & in_byte_i};
  assign nst        = u2u_pkg::next_state(st, cls);
  assign is_pair    = cp_new[u2u_pkg::CpW-1:u2u_pkg::UnitW] != '0;
  assign room       = cap_q - units_q;
  assign complete   = accept && active && (nst == u2u_pkg::StAccept);
  assign push       = complete && (!is_pair || room >= u2u_pkg::CountW'(2));

  assign push_o                = push;
  assign push_entry_o.pair     = is_pair;
  assign push_entry_o.unit0    = is_pair ?
                                 u2u_pkg::HiSurrBase + u2u_pkg::UnitW'(cp_new >> 10) :
                                 cp_new[u2u_pkg::UnitW-1:0];
  assign push_entry_o.unit1    = u2u_pkg::LoSurrBase + {6'd0, cp_new[9:0]};
  assign push_entry_o.count0   = units_q + u2u_pkg::CountW'(1);

  always_comb begin
    state_d = state_q;
    cp_d    = cp_q;
    units_d = units_q;
    if (accept) begin
      if (active) begin
        state_d = nst;
        cp_d    = cp_new;
      end
      if (push) begin
        units_d = units_q + (is_pair ? u2u_pkg::CountW'(2) : u2u_pkg::CountW'(1));
      end
      if (in_eos_i) begin
        state_d = u2u_pkg::StAccept;
        cp_d    = '0;
        units_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= '1;
      state_q <= u2u_pkg::StAccept;
      cp_q    <= '0;
      units_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      state_q <= state_d;
      cp_q    <= cp_d;
      units_q <= units_d;
    end
  end

endmodule

>>> src/u2u_queue.sv
`timescale 1ns / 1ps
module u2u_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u2u_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output u2u_pkg::entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = cnt_q == CntW'(Depth);
  assign valid_o     = cnt_q != '0;
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> src/u2u_back.sv
`timescale 1ns / 1ps
module u2u_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  u2u_pkg::entry_t             q_entry_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u2u_pkg::UnitW-1:0]   out_unit_o,
  output logic [u2u_pkg::CountW-1:0]  out_count_o,
  output logic                        out_last_o
);

  logic                        valid_q, valid_d;
  logic [u2u_pkg::UnitW-1:0]   unit_q, unit_d;
  logic [u2u_pkg::CountW-1:0]  count_q, count_d;
  logic                        last_q, last_d;
  logic                        pend_q, pend_d;
  logic [u2u_pkg::UnitW-1:0]   pend_unit_q, pend_unit_d;
  logic                        load_ok;

  assign load_ok     = !valid_q || out_ready_i;
  assign q_pop_o     = load_ok && !pend_q && q_valid_i;
  assign out_valid_o = valid_q;
  assign out_unit_o  = unit_q;
  assign out_count_o = count_q;
  assign out_last_o  = last_q;

  always_comb begin
    valid_d     = valid_q;
    unit_d      = unit_q;
    count_d     = count_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_unit_d = pend_unit_q;
    if (load_ok) begin
      if (pend_q) begin
        // low surrogate of a pair
        valid_d = 1'b1;
        unit_d  = pend_unit_q;
        count_d = count_q + u2u_pkg::CountW'(1);
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (q_valid_i) begin
        valid_d     = 1'b1;
        unit_d      = q_entry_i.unit0;
        count_d     = q_entry_i.count0;
        last_d      = !q_entry_i.pair;
        pend_d      = q_entry_i.pair;
        pend_unit_d = q_entry_i.unit1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q      <= unit_d;
    count_q     <= count_d;
    last_q      <= last_d;
    pend_unit_q <= pend_unit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

endmodule

>>> src/utf8_to_utf16_converter.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 converter. Takes one UTF-8 byte per cycle on the slave stream
// while the request queue is not full (tlast marks the end of a string, which
// clears decoder state and unit count after that byte) and emits UTF-16 units on
// the master stream; a code point above 0xFFFF comes out as a surrogate pair, tlast
// set on the final unit of the byte. The front steps the validating automaton on
// each byte; the back emitter drains one unit per cycle while the receiver is ready
// from a QUEUE_DEPTH entry request queue, and a pair never arrives faster than once
// per four bytes. Units pass the request queue, then the output register. Invalid
// sequences give no output until end of string; once cfg_wdata_i units are emitted,
// the rest of the string is dropped, and a pair that would not fit whole is dropped.
module utf8_to_utf16_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // code_unit [15:0], unit_count [31:16]
  output logic        m_axis_tlast    // last_unit
);

  logic            push;
  u2u_pkg::entry_t push_entry;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  u2u_pkg::entry_t q_entry;
  logic [15:0]     out_unit;
  logic [15:0]     out_count;

  u2u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_eos_i     (s_axis_tlast),
    .push_o       (push),
    .push_entry_o (push_entry),
    .q_full_i     (q_full)
  );

  u2u_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (q_entry)
  );

  u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_unit_o  (out_unit),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_unit};

endmodule

>>> test/utf8_to_utf16_converter_tb.sv
`timescale 1ns / 1ps
module utf8_to_utf16_converter_tb;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainGap   = 8;

  // automaton step per state, nibble i holds the next state for byte class i
  localparam logic [0:8][47:0] StepTbl = {
    48'h641117853210,
    48'h111111111111,
    48'h110101111101,
    48'h112121111121,
    48'h111121111111,
    48'h112111111121,
    48'h113131111111,
    48'h113131111131,
    48'h111111111131
  };

  typedef struct packed {
    logic [u2u_pkg::ByteW-1:0] octet;
    logic                      eos;
  } byte_req_t;

  typedef struct packed {
    logic [u2u_pkg::UnitW-1:0]  code;
    logic                       fin;
    logic [u2u_pkg::CountW-1:0] count;
  } unit_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [15:0]       cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              m_axis_tlast;

  byte_req_t         pending_bytes[$];
  byte_req_t         next_req;
  unit_t             expected_units[$];
  unit_t             got_unit;
  unit_t             want_unit;

  // decoder shadow
  logic [u2u_pkg::StateW-1:0] dec_state = u2u_pkg::StAccept;
  logic [u2u_pkg::CpW-1:0]    dec_cp    = '0;
  logic [u2u_pkg::CountW-1:0] dec_units = '0;
  logic [u2u_pkg::CountW-1:0] capacity  = 16'hFFFF;

  int unsigned       src_idle_pct  = 0;
  int unsigned       snk_stall_pct = 0;
  logic              hold_go   = 1'b0;
  logic              hold_seen = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       mismatches  = 0;

  utf8_to_utf16_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [u2u_pkg::ClassW-1:0] utf8_class(
      input logic [u2u_pkg::ByteW-1:0] b);
    if (!b[7]) return 4'd0;
    if (b < 8'h90) return 4'd1;
    if (b < 8'hA0) return 4'd9;
    if (b < 8'hC0) return 4'd7;
    case (b)
      8'hC0, 8'hC1: return 4'd8;
      8'hE0:        return 4'd10;
      8'hED:        return 4'd4;
      8'hF0:        return 4'd11;
      8'hF4:        return 4'd5;
      default:      ;
    endcase
    if (b < 8'hE0) return 4'd2;
    if (b < 8'hF0) return 4'd3;
    if (b < 8'hF4) return 4'd6;
    return 4'd8;
  endfunction

  task automatic decode_byte(input logic [u2u_pkg::ByteW-1:0] b, input logic eos);
    logic [u2u_pkg::ClassW-1:0] cls;
    logic [u2u_pkg::StateW-1:0] st;
    unit_t                      u;
    if (dec_units < capacity) begin
      cls = utf8_class(b);
      st = (dec_state > 4'd8) ? u2u_pkg::StReject : dec_state;
      if (st != u2u_pkg::StAccept) begin
        dec_cp = {dec_cp[u2u_pkg::CpW-7:0], b[5:0]};
      end else begin
        dec_cp = u2u_pkg::CpW'(8'hFF >> cls) & u2u_pkg::CpW'(b);
      end
      st = StepTbl[st][4*cls +: 4];
      dec_state = st;
      if (st == u2u_pkg::StAccept) begin
        if (dec_cp > 21'h00FFFF) begin
          if (32'(capacity) - 32'(dec_units) >= 2) begin
            u.code  = u2u_pkg::HiSurrBase + u2u_pkg::UnitW'(dec_cp >> 10);
            u.fin   = 1'b0;
            u.count = dec_units + 16'd1;
            expected_units.push_back(u);
            u.code  = u2u_pkg::LoSurrBase + u2u_pkg::UnitW'(dec_cp[9:0]);
            u.fin   = 1'b1;
            u.count = dec_units + 16'd2;
            expected_units.push_back(u);
            dec_units = dec_units + 16'd2;
          end
        end else begin
          u.code  = dec_cp[u2u_pkg::UnitW-1:0];
          u.fin   = 1'b1;
          u.count = dec_units + 16'd1;
          expected_units.push_back(u);
          dec_units = dec_units + 16'd1;
        end
      end
    end
    if (eos) begin
      dec_state = u2u_pkg::StAccept;
      dec_cp    = '0;
      dec_units = '0;
    end
  endtask

  task automatic report(input string what, input unit_t want, input unit_t got);
    if (mismatches < 10) begin
      $display("%0t %s: expected unit %h last %b count %0d, got unit %h last %b count %0d",
               $time, what, want.code, want.fin, want.count, got.code, got.fin, got.count);
    end
    mismatches++;
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_req = pending_bytes.pop_front();
          s_axis_tdata  <= next_req.octet;
          s_axis_tlast  <= next_req.eos;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // unit monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_unit.code  = m_axis_tdata[15:0];
        got_unit.fin   = m_axis_tlast;
        got_unit.count = m_axis_tdata[31:16];
        if (expected_units.size() == 0) begin
          report("unexpected unit", '0, got_unit);
        end else begin
          want_unit = expected_units.pop_front();
          if (want_unit.code !== got_unit.code || want_unit.fin !== got_unit.fin ||
              want_unit.count !== got_unit.count) begin
            report("unit mismatch", want_unit, got_unit);
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog on cycles without progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // first byte of the sequence sits in the highest used byte of seq
  task automatic push_seq(input int n, input logic [31:0] seq, input logic eos);
    byte_req_t r;
    for (int i = n - 1; i >= 0; i--) begin
      r.octet = seq[8*i +: 8];
      r.eos   = eos && (i == 0);
      pending_bytes.push_back(r);
    end
  endtask

  task automatic gen_string(input int nchars, input int unsigned err_pct);
    logic [31:0] seq;
    logic [20:0] cp;
    int          n;
    logic        eos;
    for (int c = 0; c < nchars; c++) begin
      eos = (c == nchars - 1);
      case ($urandom_range(3))
        0: begin
          cp  = 21'($urandom_range(8'h7F));
          n   = 1;
          seq = {25'd0, cp[6:0]};
        end
        1: begin
          cp  = 21'($urandom_range(11'h7FF, 8'h80));
          n   = 2;
          seq = {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
        end
        2: begin
          cp = 21'($urandom_range(16'hFFFF, 12'h800));
          if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp - 21'h800;
          n   = 3;
          seq = {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        end
        default: begin
          cp  = 21'($urandom_range(21'h10FFFF, 21'h10000));
          n   = 4;
          seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        end
      endcase
      if ($urandom_range(99) < err_pct) begin
        if ($urandom_range(1) == 0 || n == 1) begin
          n   = 1;
          seq = $urandom_range(255);
        end else begin
          // truncated sequence
          n   = n - 1;
          seq = seq >> 8;
        end
      end
      push_seq(n, seq, eos);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_units.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [15:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    capacity = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned src, input int unsigned snk);
    @(posedge clk_i);
    src_idle_pct  <= src;
    snk_stall_pct <= snk;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_capacity(16'hFFFF);
    push_seq(2, 32'h0000_007F, 1'b0);
    push_seq(2, 32'h0000_C280, 1'b0);
    push_seq(3, 32'h00E0_A080, 1'b0);
    push_seq(3, 32'h00EF_BFBF, 1'b0);
    push_seq(4, 32'hF090_8080, 1'b0);
    push_seq(4, 32'hF48F_BFBF, 1'b1);
    // overlong lead, then sticky reject
    push_seq(2, 32'h0000_C041, 1'b1);
    // encoded surrogate
    push_seq(3, 32'h00ED_A080, 1'b1);
    // incomplete at end of string
    push_seq(2, 32'h0000_E282, 1'b1);
    push_seq(1, 32'h0000_00FF, 1'b1);
    push_seq(1, 32'h0000_0041, 1'b1);

    set_capacity(16'h0000);
    repeat (3) gen_string($urandom_range(1, 3), 10);
    push_seq(1, 32'h0000_0041, 1'b1);

    // pair does not fit in one free unit
    set_capacity(16'h0001);
    push_seq(4, 32'hF09F_9880, 1'b0);
    push_seq(2, 32'h0000_4142, 1'b1);
    push_seq(2, 32'h0000_C3A9, 1'b1);

    set_capacity(16'h0002);
    push_seq(4, 32'hF09F_9880, 1'b0);
    push_seq(1, 32'h0000_0041, 1'b1);

    set_capacity(16'h0003);
    repeat (6) gen_string($urandom_range(1, 6), 15);

    set_capacity(16'hFFFF);
    set_idling(0, 0);
    repeat (6) gen_string($urandom_range(1, 6), 15);
    wait_drained();
    set_idling(64, 0);
    repeat (6) gen_string($urandom_range(1, 6), 15);
    wait_drained();
    set_idling(0, 64);
    repeat (6) gen_string($urandom_range(1, 6), 15);
    wait_drained();
    set_idling(31, 31);
    repeat (6) gen_string($urandom_range(1, 6), 15);

    set_capacity(16'($urandom_range(6, 2)));
    repeat (6) gen_string($urandom_range(2, 6), 10);

    // receiver holds off while bytes keep coming
    set_capacity(16'hFFFF);
    set_idling(0, 0);
    @(posedge clk_i);
    hold_go <= ~hold_go;
    repeat (6) gen_string($urandom_range(2, 6), 5);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/u2u_pkg.sv
src/u2u_front.sv
src/u2u_queue.sv
src/u2u_back.sv
src/utf8_to_utf16_converter.sv
test/utf8_to_utf16_converter_tb.sv
